>>> hdl/flpm_pkg.sv
// Package for the four-level page map writer: sizes, entry bit positions,
// register indexes, shared types and the sequencer state encoding.
// No dependencies; every other file in this folder imports it.
package flpm_pkg;

    // Table store geometry. The frame count must stay a power of two.
    localparam int TABLE_PAGES_LOG2 = 6;
    localparam int TABLE_PAGES      = 1 << TABLE_PAGES_LOG2;
    localparam int FRAME_W          = TABLE_PAGES_LOG2;
    localparam int IDX_W            = 9;
    localparam int ENTRIES          = 1 << IDX_W;
    localparam int ADDR_W           = FRAME_W + IDX_W;
    localparam int DEPTH            = TABLE_PAGES * ENTRIES;
    localparam int LEVELS           = 4;

    // Field widths.
    localparam int ENTRY_W = 64;
    localparam int VPN_W   = 36;
    localparam int PFN_W   = 40;
    localparam int ROOT_W  = 6;
    localparam int ALLOC_W = 7;
    localparam int NF_MIN  = $clog2(TABLE_PAGES + 1);
    localparam int NF_W    = (ALLOC_W > NF_MIN) ? ALLOC_W : NF_MIN;

    // Entry layout.
    localparam int ADDR_LO = 12;
    localparam int BIT_P   = 0;
    localparam int BIT_W   = 1;
    localparam int BIT_U   = 2;
    localparam int BIT_NX  = 63;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_START = 1'd1;
    localparam int ALLOC_START_RST = 1;

    // The directory level, last one before the leaf table.
    localparam int LEVEL_W = 2;
    localparam logic [LEVEL_W-1:0] LEVEL_LAST = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd3;

    typedef struct packed {
        logic [LEVELS-1:0][IDX_W-1:0] idx;
        logic                         user;
        logic [ENTRY_W-1:0]           leaf;
    } t_job;

    typedef struct packed {
        logic               status;
        logic [1:0]         tables_added;
        logic [ENTRY_W-1:0] leaf_entry;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_ZERO,
        S_LINK,
        S_LEAF,
        S_DONE
    } t_state;

    function automatic logic [FRAME_W-1:0] frame_of(input logic [ENTRY_W-1:0] entry);
        return entry[ADDR_LO +: FRAME_W];
    endfunction

endpackage

>>> hdl/four_level_page_map_writer.sv
// Top level of the four-level page map writer: front end, request queue,
// table walker and the result register.
// Depends on flpm_pkg, flpm_front, flpm_queue and flpm_back.
//
// Usage:
// Each transfer on the input channel maps one 4 KiB virtual page to a physical
// frame. The walker descends the root, directory-pointer and directory levels
// in an on-chip store of 64 tables of 512 entries, allocates zeroed tables from
// a bump allocator where a level is missing, writes the leaf entry and returns
// one result transfer: status, tables allocated and the leaf entry written.
// The store has one port, so each request is walked alone. Each table
// allocated is first zeroed entry by entry and then linked into its
// parent. Two requests can wait in the queue behind the walker, and one
// finished result waits in the output register while the walker starts
// on the next request.
// After reset the store's 32768 entries are cleared one entry per cycle; the
// input ready stays low during that time, while configuration writes are
// taken. When the receiver stalls, the result holds, the walker stops at its
// next result, and the input side keeps taking requests until the queue fills.
module four_level_page_map_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [35:0] i_virt_page,
    input  logic [39:0] i_phys_frame,
    input  logic        i_want_present,
    input  logic        i_want_write,
    input  logic        i_want_user,
    input  logic        i_want_exec,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic [1:0]  o_tables_added,
    output logic [63:0] o_leaf_entry
);
    import flpm_pkg::*;

    t_back_status status;
    t_cfg_wr      cfg;
    t_job         push_job;
    t_job         q_job;
    t_result      res;
    logic         push;
    logic         q_full;
    logic         q_valid;
    logic         pop;
    logic         res_valid;
    logic         res_ready;
    logic         r_out_valid;
    t_result      r_out;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    flpm_front u_front (
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_virt_page    (i_virt_page),
        .i_phys_frame   (i_phys_frame),
        .i_want_present (i_want_present),
        .i_want_write   (i_want_write),
        .i_want_user    (i_want_user),
        .i_want_exec    (i_want_exec),
        .i_status       (status),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_job          (push_job)
    );

    flpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (q_job)
    );

    flpm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_pop       (pop),
        .o_status    (status),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // The result register takes a new result whenever it is empty or its
    // current result is being transferred in the same cycle.
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_tables_added = r_out.tables_added;
    assign o_leaf_entry   = r_out.leaf_entry;

endmodule

>>> hdl/flpm_front.sv
// Front end of the page map writer: input handshake and classification of
// one request into table indices, the intermediate user flag and the leaf entry.
// Depends on flpm_pkg.
module flpm_front (
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [35:0]           i_virt_page,
    input  logic [39:0]           i_phys_frame,
    input  logic                  i_want_present,
    input  logic                  i_want_write,
    input  logic                  i_want_user,
    input  logic                  i_want_exec,
    input  flpm_pkg::t_back_status i_status,
    input  logic                  i_q_full,
    output logic                  o_push,
    output flpm_pkg::t_job        o_job
);
    import flpm_pkg::*;

    // No request is taken while the store is being cleared after reset.
    assign o_in_ready = !i_q_full && !i_status.clearing;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        for (int k = 0; k < LEVELS; k++) begin
            o_job.idx[k] = i_virt_page[(LEVELS-1-k)*IDX_W +: IDX_W];
        end
        o_job.user = i_want_user;
        o_job.leaf = '0;
        o_job.leaf[ADDR_LO +: PFN_W] = i_phys_frame;
        o_job.leaf[BIT_P]  = i_want_present;
        o_job.leaf[BIT_W]  = i_want_write;
        o_job.leaf[BIT_U]  = i_want_user;
        o_job.leaf[BIT_NX] = !i_want_exec;
    end

endmodule

>>> hdl/flpm_queue.sv
// Two-entry queue of classified requests between the front end and the walker.
// Depends on flpm_pkg.
module flpm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  flpm_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output flpm_pkg::t_job o_job
);
    import flpm_pkg::*;

    t_job       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop && o_valid) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

>>> hdl/flpm_back.sv
// Walker of the page map writer: owns the table store, the frame allocator
// and the configuration registers, and carries out one queued request at a time.
// Depends on flpm_pkg.
module flpm_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  flpm_pkg::t_cfg_wr       i_cfg,
    input  logic                    i_q_valid,
    input  flpm_pkg::t_job          i_q_job,
    output logic                    o_pop,
    output flpm_pkg::t_back_status  o_status,
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output flpm_pkg::t_result       o_res
);
    import flpm_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    t_state             r_state;
    t_state             n_state;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [ADDR_W-1:0]  n_clr_addr;
    logic [IDX_W-1:0]   r_zcnt;
    logic [IDX_W-1:0]   n_zcnt;
    t_job               r_job;
    t_job               n_job;
    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] n_level;
    logic [FRAME_W-1:0] r_frame;
    logic [FRAME_W-1:0] n_frame;
    logic [1:0]         r_added;
    logic [1:0]         n_added;
    logic               r_fail;
    logic               n_fail;
    logic [NF_W-1:0]    r_next_free;
    logic [NF_W-1:0]    n_next_free;
    logic [ROOT_W-1:0]  r_root;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               out_of_pages;
    logic [FRAME_W-1:0] new_frame;
    logic [IDX_W-1:0]   cur_idx;
    logic [ENTRY_W-1:0] link_entry;

    assign out_of_pages = (r_next_free >= NF_W'(TABLE_PAGES));
    assign new_frame    = r_next_free[FRAME_W-1:0];
    assign cur_idx      = r_job.idx[r_level];

    always_comb begin
        link_entry = '0;
        link_entry[ADDR_LO +: FRAME_W] = new_frame;
        link_entry[BIT_P] = 1'b1;
        link_entry[BIT_W] = 1'b1;
        link_entry[BIT_U] = r_job.user;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_CHECK;
            S_CHECK: begin
                if (r_rdata[BIT_P]) begin
                    n_state = (r_level == LEVEL_LAST) ? S_LEAF : S_READ;
                end else if (out_of_pages) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                if (r_zcnt == IDX_W'(ENTRIES - 1)) begin
                    n_state = S_LINK;
                end
            end
            S_LINK: n_state = (r_level == LEVEL_LAST) ? S_LEAF : S_READ;
            S_LEAF: n_state = S_DONE;
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Outputs, store controls and datapath updates.
    always_comb begin
        mem_we      = 1'b0;
        mem_addr    = {r_frame, cur_idx};
        mem_wdata   = '0;
        o_pop       = 1'b0;
        o_res_valid = 1'b0;
        n_clr_addr  = r_clr_addr;
        n_zcnt      = r_zcnt;
        n_job       = r_job;
        n_level     = r_level;
        n_frame     = r_frame;
        n_added     = r_added;
        n_fail      = r_fail;
        n_next_free = r_next_free;
        case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_addr   = r_clr_addr;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
            end
            S_IDLE: begin
                o_pop = i_q_valid;
                if (i_q_valid) begin
                    n_job   = i_q_job;
                    n_level = '0;
                    n_frame = FRAME_W'(r_root);
                    n_added = 2'd0;
                    n_fail  = 1'b0;
                end
            end
            S_READ: begin
                mem_addr = {r_frame, cur_idx};
            end
            S_CHECK: begin
                if (r_rdata[BIT_P]) begin
                    n_frame = frame_of(r_rdata);
                    if (r_level != LEVEL_LAST) begin
                        n_level = r_level + LEVEL_W'(1);
                    end
                end else if (out_of_pages) begin
                    n_fail = 1'b1;
                end else begin
                    n_zcnt = '0;
                end
            end
            S_ZERO: begin
                mem_we   = 1'b1;
                mem_addr = {new_frame, r_zcnt};
                n_zcnt   = r_zcnt + IDX_W'(1);
            end
            S_LINK: begin
                // The entry is written after the sweep, so it survives even
                // when the new table lands on the frame being walked.
                mem_we      = 1'b1;
                mem_addr    = {r_frame, cur_idx};
                mem_wdata   = link_entry;
                n_added     = r_added + 2'd1;
                n_next_free = r_next_free + NF_W'(1);
                n_frame     = new_frame;
                if (r_level != LEVEL_LAST) begin
                    n_level = r_level + LEVEL_W'(1);
                end
            end
            S_LEAF: begin
                mem_we    = 1'b1;
                mem_addr  = {r_frame, r_job.idx[LEVEL_LEAF]};
                mem_wdata = r_job.leaf;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign o_status.clearing = (r_state == S_CLEAR);
    assign o_res.status       = r_fail;
    assign o_res.tables_added = r_added;
    assign o_res.leaf_entry   = r_fail ? '0 : r_job.leaf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_next_free <= NF_W'(ALLOC_START_RST);
            r_root      <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (i_cfg.we && i_cfg.index == CFG_ALLOC_START) begin
                r_next_free <= NF_W'(i_cfg.data);
            end else begin
                r_next_free <= n_next_free;
            end
            if (i_cfg.we && i_cfg.index == CFG_ROOT_FRAME) begin
                r_root <= i_cfg.data[ROOT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_zcnt  <= n_zcnt;
        r_job   <= n_job;
        r_level <= n_level;
        r_frame <= n_frame;
        r_added <= n_added;
        r_fail  <= n_fail;
    end

    // Single-port table store with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

endmodule

>>> tb/four_level_page_map_writer_tb.sv
// Self-checking testbench for the four-level page map writer.
// A predictor with its own table store follows every accepted transfer and
// checks each result. Depends on flpm_pkg and four_level_page_map_writer.
`timescale 1ns / 1ps

module four_level_page_map_writer_tb;

    import flpm_pkg::*;

    localparam int SETTLE_CYCLES = 20;
    // Long enough for the walker to finish two requests that each allocate
    // three tables, so the result side is what fills the block.
    localparam int LONG_HOLD     = 4000;
    localparam int RANDOM_PHASES = 3;

    typedef struct packed {
        logic [35:0] vpn;
        logic [39:0] pfn;
        logic        present;
        logic        write;
        logic        user;
        logic        exec;
    } t_map_req;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [0:0]  i_cfg_index    = '0;
    logic [6:0]  i_cfg_data     = '0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [35:0] i_virt_page    = '0;
    logic [39:0] i_phys_frame   = '0;
    logic        i_want_present = 1'b0;
    logic        i_want_write   = 1'b0;
    logic        i_want_user    = 1'b0;
    logic        i_want_exec    = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic        o_status;
    logic [1:0]  o_tables_added;
    logic [63:0] o_leaf_entry;

    four_level_page_map_writer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_virt_page    (i_virt_page),
        .i_phys_frame   (i_phys_frame),
        .i_want_present (i_want_present),
        .i_want_write   (i_want_write),
        .i_want_user    (i_want_user),
        .i_want_exec    (i_want_exec),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_tables_added (o_tables_added),
        .o_leaf_entry   (o_leaf_entry)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state: its own copy of the table store and the registers.
    logic [63:0]  pt_mem [0:DEPTH-1];
    logic [5:0]   root_cfg;
    int unsigned  alloc_next;

    t_map_req     map_queue [$];
    t_result      expected_results [$];
    int           pushed_count   = 0;
    int           accepted_count = 0;
    int           errors         = 0;
    logic         in_fire        = 1'b0;
    logic         out_fire       = 1'b0;
    bit           send_burst     = 1'b0;
    bit           recv_burst     = 1'b0;
    bit           hold_request   = 1'b0;
    int           send_gap       = 0;
    int           recv_wait      = 0;
    logic [8:0]   hot_idx [0:3];

    function automatic int draw_gap(input bit no_idle);
        return no_idle ? 0 : $urandom_range(0, 14);
    endfunction

    // Walks the three upper levels, allocating and linking missing tables,
    // then writes the leaf entry; stops with status set when out of table pages.
    function automatic t_result walk_and_map(input t_map_req rq);
        t_result     r;
        logic [63:0] link_bits;
        logic [63:0] entry;
        logic [63:0] leaf;
        logic [8:0]  idx;
        int unsigned frame;
        int unsigned slot_at;
        int unsigned nf;
        int          lvl;
        int          k;
        r = '0;
        link_bits = rq.user ? 64'h7 : 64'h3;
        frame = root_cfg % TABLE_PAGES;
        for (lvl = 0; lvl < 3; lvl++) begin
            idx = rq.vpn[(27 - 9 * lvl) +: 9];
            slot_at = frame * ENTRIES + idx;
            entry = pt_mem[slot_at];
            if (!entry[0]) begin
                // Out of table pages: stop here, keep what higher levels got.
                if (alloc_next >= TABLE_PAGES) begin
                    r.status = 1'b1;
                    return r;
                end
                nf = alloc_next;
                alloc_next++;
                for (k = 0; k < ENTRIES; k++) begin
                    pt_mem[nf * ENTRIES + k] = '0;
                end
                entry = (64'(nf) << 12) | link_bits;
                pt_mem[slot_at] = entry;
                r.tables_added = r.tables_added + 2'd1;
            end
            frame = 32'(entry[51:12] % TABLE_PAGES);
        end
        leaf = {~rq.exec, 11'b0, rq.pfn, 9'b0, rq.user, rq.write, rq.present};
        pt_mem[frame * ENTRIES + rq.vpn[8:0]] = leaf;
        r.leaf_entry = leaf;
        return r;
    endfunction

    function automatic t_map_req make_req(input logic [35:0] vpn, input logic [39:0] pfn,
                                          input logic [3:0] flags);
        t_map_req rq;
        rq.vpn = vpn;
        rq.pfn = pfn;
        {rq.present, rq.write, rq.user, rq.exec} = flags;
        return rq;
    endfunction

    // Mostly walks through a few hot indexes so that levels are shared and
    // reused; some items are fully random.
    function automatic t_map_req rand_req();
        logic [8:0]  ix [0:3];
        logic [35:0] vpn;
        logic [39:0] pfn;
        int          lv;
        for (lv = 0; lv < 4; lv++) begin
            if ($urandom_range(0, 3) != 0 && lv < 3)
                ix[lv] = hot_idx[$urandom_range(0, 3)];
            else
                ix[lv] = 9'($urandom_range(0, 511));
        end
        vpn = {ix[0], ix[1], ix[2], ix[3]};
        if ($urandom_range(0, 9) == 0)
            vpn = {4'($urandom), 32'($urandom)};
        case ($urandom_range(0, 7))
            0:       pfn = '0;
            1:       pfn = '1;
            default: pfn = {8'($urandom), 32'($urandom)};
        endcase
        return make_req(vpn, pfn, 4'($urandom));
    endfunction

    task automatic push_item(input t_map_req rq);
        map_queue.push_back(rq);
        pushed_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [6:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_ROOT_FRAME) begin
            root_cfg = data[5:0];
        end else begin
            alloc_next = 32'(data);
        end
    endtask

    // Waits until every transfer is taken and every result is back, then lets
    // the walker settle before anything else changes.
    task automatic drain_and_settle();
        do @(negedge i_clk);
        while (accepted_count != pushed_count || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [6:0] root_data, input logic [6:0] alloc_data,
                             input int n_items, input bit low_pool, input bit long_hold);
        int k;
        write_reg(CFG_ROOT_FRAME, root_data);
        write_reg(CFG_ALLOC_START, alloc_data);
        send_burst = ($urandom_range(0, 2) == 0);
        recv_burst = ($urandom_range(0, 2) == 0);
        for (k = 0; k < 4; k++) begin
            hot_idx[k] = low_pool ? 9'(k) : 9'($urandom_range(0, 511));
        end
        if (!low_pool) begin
            hot_idx[0] = 9'd0;
            hot_idx[1] = 9'd511;
        end
        for (k = 0; k < n_items; k++) begin
            push_item(rand_req());
        end
        if (long_hold) begin
            @(posedge i_clk);
            hold_request = 1'b1;
        end
        drain_and_settle();
    endtask

    task automatic note_failure(input t_result exp, input t_result got, input bit orphan);
        errors++;
        if (errors <= 10) begin
            if (orphan)
                $display("%0t: result with nothing expected: status %0d tables %0d leaf %h",
                         $realtime, got.status, got.tables_added, got.leaf_entry);
            else
                $display("%0t: expected status %0d tables %0d leaf %h, got %0d %0d %h",
                         $realtime, exp.status, exp.tables_added, exp.leaf_entry,
                         got.status, got.tables_added, got.leaf_entry);
        end
    endtask

    // Driver: one item on the input channel, held until its transfer.
    always @(negedge i_clk) begin : drive_items
        t_map_req nxt;
        if (i_rst_n && !(i_in_valid && !in_fire)) begin
            if (in_fire)
                send_gap = draw_gap(send_burst);
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (map_queue.size() != 0) begin
                nxt = map_queue.pop_front();
                i_virt_page    <= nxt.vpn;
                i_phys_frame   <= nxt.pfn;
                i_want_present <= nxt.present;
                i_want_write   <= nxt.write;
                i_want_user    <= nxt.user;
                i_want_exec    <= nxt.exec;
                i_in_valid     <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: ready drops for a drawn number of cycles after each transfer.
    always @(negedge i_clk) begin
        if (out_fire)
            recv_wait = draw_gap(recv_burst);
        if (hold_request) begin
            hold_request = 1'b0;
            recv_wait = LONG_HOLD;
        end
        if (recv_wait > 0) begin
            recv_wait--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: checks results, then predicts for a newly accepted request.
    always @(posedge i_clk) begin : watch_ports
        t_result  got;
        t_result  exp;
        t_map_req seen;
        in_fire  <= i_rst_n && i_in_valid && o_in_ready;
        out_fire <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.status       = o_status;
            got.tables_added = o_tables_added;
            got.leaf_entry   = o_leaf_entry;
            if (expected_results.size() == 0) begin
                note_failure(got, got, 1'b1);
            end else begin
                exp = expected_results.pop_front();
                if (got.status !== exp.status || got.tables_added !== exp.tables_added ||
                    got.leaf_entry !== exp.leaf_entry)
                    note_failure(exp, got, 1'b0);
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            seen = make_req(i_virt_page, i_phys_frame,
                            {i_want_present, i_want_write, i_want_user, i_want_exec});
            expected_results.push_back(walk_and_map(seen));
            accepted_count++;
        end
    end

    initial begin : stimulus
        int k;
        int r;
        for (k = 0; k < DEPTH; k++) begin
            pt_mem[k] = '0;
        end
        root_cfg   = '0;
        alloc_next = ALLOC_START_RST;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset settings written explicitly.
        write_reg(CFG_ROOT_FRAME, 7'd0);
        write_reg(CFG_ALLOC_START, 7'd1);
        push_item(make_req(36'h0, 40'h0, 4'b0000));
        push_item(make_req(36'h0, '1, 4'b1111));
        push_item(make_req('1, '1, 4'b1111));
        push_item(make_req('1, 40'h0, 4'b0000));
        // Every flag combination in the first leaf table.
        for (k = 0; k < 16; k++) begin
            push_item(make_req(36'(k), 40'hABCDE12340 + 40'(k), 4'(k)));
        end
        push_item(make_req({9'd0, 9'd511, 9'd0, 9'd7}, 40'h8000000001, 4'b1010));
        push_item(make_req({9'd0, 9'd0, 9'd300, 9'd5}, 40'h00000FFFC0, 4'b0101));
        drain_and_settle();

        // The root now sits on a leaf table: entries with only some flag bits
        // set are not present, and large frame numbers wrap.
        run_phase(7'd3, 7'd60, 60, 1'b1, 1'b0);
        // Reallocation over live tables, with a long stall on the result side.
        run_phase(7'd0, 7'd1, 200, 1'b0, 1'b1);
        run_phase(7'h7F, 7'd0, 200, 1'b0, 1'b0);
        // Nothing left to allocate: only fully present walks complete.
        run_phase(7'd0, 7'd64, 80, 1'b0, 1'b0);
        run_phase(7'd5, 7'd127, 60, 1'b1, 1'b0);
        run_phase(7'd40, 7'd2, 200, 1'b0, 1'b0);
        for (r = 0; r < RANDOM_PHASES; r++) begin
            run_phase(7'($urandom_range(0, 127)),
                      ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                  : 7'($urandom_range(0, 64)),
                      150, 1'($urandom_range(0, 1)), 1'b0);
        end

        if (errors == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
hdl/flpm_pkg.sv
hdl/flpm_front.sv
hdl/flpm_queue.sv
hdl/flpm_back.sv
hdl/four_level_page_map_writer.sv
tb/four_level_page_map_writer_tb.sv
